FILE: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the bank register file
// Item kinds, register offsets and the decoded request passed front to back.
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_VIDEO = 2'd2;

	localparam logic [3:0] REG_CHR_FIRST = 4'd0;
	localparam logic [3:0] REG_PRG       = 4'd8;
	localparam logic [3:0] REG_MIRROR    = 4'd9;
	localparam logic [3:0] REG_IRQ_CTRL  = 4'd10;
	localparam logic [3:0] REG_IRQ_LO    = 4'd11;
	localparam logic [3:0] REG_IRQ_HI    = 4'd12;

	localparam logic [7:0] MIRROR_MASK = 8'h03;
	localparam logic [1:0] WAIT_START  = 2'd2;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_BANK,
		OP_IRQ_CTRL,
		OP_IRQ_LO,
		OP_IRQ_HI,
		OP_TICK,
		OP_VIDEO
	} op_code_t;

	typedef struct packed {
		op_code_t   code;
		logic [3:0] target;
		logic [7:0] value;
	} op_t;

endpackage

FILE: rtl/brf_front.sv
// ----------------------------------------------------------------------------
// brf_front: request intake and decode
// Accepts requests and turns each into a decoded operation held in one stage.
// ----------------------------------------------------------------------------
module brf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    kind,
	input  logic [3:0]    reg_offset,
	input  logic [7:0]    write_data,
	output logic          op_valid,
	input  logic          op_ready,
	output brf_pkg::op_t  op
);

	brf_pkg::op_t dec;
	logic         vld_s1;
	brf_pkg::op_t op_s1;

	always_comb begin
		dec.code   = brf_pkg::OP_NONE;
		dec.target = reg_offset;
		dec.value  = write_data;
		unique case (kind)
			brf_pkg::KIND_WRITE: begin
				unique case (reg_offset) inside
					[brf_pkg::REG_CHR_FIRST:brf_pkg::REG_PRG]: dec.code = brf_pkg::OP_BANK;
					brf_pkg::REG_MIRROR: begin
						dec.code  = brf_pkg::OP_BANK;
						dec.value = write_data & brf_pkg::MIRROR_MASK;
					end
					brf_pkg::REG_IRQ_CTRL: dec.code = brf_pkg::OP_IRQ_CTRL;
					brf_pkg::REG_IRQ_LO:   dec.code = brf_pkg::OP_IRQ_LO;
					brf_pkg::REG_IRQ_HI:   dec.code = brf_pkg::OP_IRQ_HI;
					default:               dec.code = brf_pkg::OP_NONE;
				endcase
			end
			brf_pkg::KIND_TICK:  dec.code = brf_pkg::OP_TICK;
			brf_pkg::KIND_VIDEO: dec.code = brf_pkg::OP_VIDEO;
			default:             dec.code = brf_pkg::OP_NONE;
		endcase
	end

	assign in_ready = !vld_s1 || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= dec;
		end
	end

	assign op_valid = vld_s1;
	assign op       = op_s1;

endmodule

FILE: rtl/brf_queue.sv
// ----------------------------------------------------------------------------
// brf_queue: short operation queue
// Two-entry queue that decouples the decode stage from the timer back end.
// ----------------------------------------------------------------------------
module brf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  brf_pkg::op_t  push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output brf_pkg::op_t  pop_op
);

	localparam int unsigned PTR_W = $clog2(brf_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(brf_pkg::QUEUE_DEPTH + 1);

	brf_pkg::op_t     mem_q [brf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(brf_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_op     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/brf_back.sv
// ----------------------------------------------------------------------------
// brf_back: timer state and result register
// Carries out decoded operations on the interrupt timer and registers results.
// ----------------------------------------------------------------------------
module brf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          op_valid,
	output logic          op_ready,
	input  brf_pkg::op_t  op,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          irq_out,
	output logic          update_valid,
	output logic [3:0]    update_target,
	output logic [7:0]    update_value
);

	logic        latch_mode_q;
	logic [15:0] counter_q;
	logic [15:0] reload_q;
	logic        enabled_q;
	logic [1:0]  wait_q;
	logic        level_q;
	logic        out_valid_q;
	logic        irq_q;
	logic        upd_valid_q;
	logic [3:0]  upd_target_q;
	logic [7:0]  upd_value_q;

	logic [15:0] counter_n;
	logic [15:0] reload_n;
	logic        enabled_n;
	logic [1:0]  wait_n;
	logic        level_n;
	logic        upd_n;
	logic        take;

	assign op_ready = !out_valid_q || out_ready;
	assign take     = op_valid && op_ready;

	always_comb begin
		counter_n = counter_q;
		reload_n  = reload_q;
		enabled_n = enabled_q;
		wait_n    = wait_q;
		level_n   = level_q;
		upd_n     = 1'b0;
		case (op.code)
			brf_pkg::OP_BANK: upd_n = 1'b1;
			brf_pkg::OP_IRQ_CTRL: begin
				enabled_n = op.value[0];
				if (latch_mode_q) begin
					counter_n = reload_q;
				end
				wait_n  = '0;
				level_n = 1'b0;
				if (enabled_n && counter_n == '0) begin
					enabled_n = 1'b0;
					wait_n    = brf_pkg::WAIT_START;
				end
			end
			brf_pkg::OP_IRQ_LO: begin
				if (latch_mode_q) begin
					reload_n[7:0] = op.value;
				end else begin
					counter_n[7:0] = op.value;
				end
			end
			brf_pkg::OP_IRQ_HI: begin
				if (latch_mode_q) begin
					reload_n[15:8] = op.value;
				end else begin
					counter_n[15:8] = op.value;
				end
			end
			brf_pkg::OP_TICK: begin
				if (enabled_q) begin
					if (counter_q != '0) begin
						counter_n = counter_q - 16'd1;
					end
					if (counter_n == '0) begin
						enabled_n = 1'b0;
						wait_n    = brf_pkg::WAIT_START;
					end
				end
			end
			brf_pkg::OP_VIDEO: begin
				if (wait_q != '0) begin
					wait_n = wait_q - 2'd1;
					if (wait_n == '0) begin
						level_n = 1'b1;
					end
				end
			end
			default: upd_n = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_mode_q <= 1'b1;
			counter_q    <= '0;
			reload_q     <= '0;
			enabled_q    <= 1'b0;
			wait_q       <= '0;
			level_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				latch_mode_q <= cfg_wdata;
			end
			if (take) begin
				counter_q <= counter_n;
				reload_q  <= reload_n;
				enabled_q <= enabled_n;
				wait_q    <= wait_n;
				level_q   <= level_n;
			end
			if (op_ready) begin
				out_valid_q <= op_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			irq_q        <= level_n;
			upd_valid_q  <= upd_n;
			upd_target_q <= upd_n ? op.target : '0;
			upd_value_q  <= upd_n ? op.value : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign irq_out       = irq_q;
	assign update_valid  = upd_valid_q;
	assign update_target = upd_target_q;
	assign update_value  = upd_value_q;

endmodule

FILE: rtl/bank_register_file_with_irq_counter.sv
// ----------------------------------------------------------------------------
// bank_register_file_with_irq_counter: mapper registers with interrupt timer
// Bank and mirroring write reporting plus a 16-bit down-counting IRQ timer.
// ----------------------------------------------------------------------------
// Channel   Signals                                     Direction
// input     in_valid/in_ready, kind, reg_offset,        in
//           write_data
// output    out_valid/out_ready, irq_out, update_valid, out
//           update_target, update_value
// config    cfg_we, cfg_wdata (latch mode)              in
//
// One request per cycle is sustained while the output is not stalled; each
// result passes the decode stage, the queue and then the result register.
// The back-end timer update sets the rate: one op per cycle unless stalled.
// Reset clears the timer and sets latch mode; no clearing pass is needed.
// A stalled output fills the two-entry queue and then holds off requests.
// ----------------------------------------------------------------------------
module bank_register_file_with_irq_counter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [3:0] reg_offset,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       irq_out,
	output logic       update_valid,
	output logic [3:0] update_target,
	output logic [7:0] update_value
);

	logic         dec_valid;
	logic         dec_ready;
	brf_pkg::op_t dec_op;
	logic         q_valid;
	logic         q_ready;
	brf_pkg::op_t q_op;

	brf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.reg_offset (reg_offset),
		.write_data (write_data),
		.op_valid   (dec_valid),
		.op_ready   (dec_ready),
		.op         (dec_op)
	);

	brf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (dec_valid),
		.push_ready (dec_ready),
		.push_op    (dec_op),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_op     (q_op)
	);

	brf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.op_valid      (q_valid),
		.op_ready      (q_ready),
		.op            (q_op),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.irq_out       (irq_out),
		.update_valid  (update_valid),
		.update_target (update_target),
		.update_value  (update_value)
	);

endmodule
